// File: hw/rtl/lwbtc_pkg.sv
// ---------------------------------------------------------------------------
// lwbtc_pkg
// Shared types and codes for the LRU write-back tag cache: command codes,
// the lookup chain, the collect chain, the broadcast control and cell status.
// ---------------------------------------------------------------------------
package lwbtc_pkg;

	localparam int TAG_W     = 32;
	localparam int WAY_OUT_W = 3;

	typedef logic [TAG_W-1:0] tag_t;

	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	// Ripples from cell 0 upwards: has any lower cell matched / been free
	typedef struct packed {
		logic match_seen;
		logic free_seen;
	} lookup_t;

	// Broadcast to every cell once the lookup chain has settled
	typedef struct packed {
		logic write;
		logic upd;
		logic any_match;
		logic any_free;
	} ctrl_t;

	// Ripples from cell 0 upwards: data of the selected cell, OR-collected
	typedef struct packed {
		logic sel;
		logic dirty;
		tag_t tag;
	} collect_t;

	// Per-cell status, watched at the top level
	typedef struct packed {
		logic sel;
		logic lru;
		logic valid;
	} stat_t;

endpackage

// File: hw/rtl/lru_write_back_tag_cache.sv
// ---------------------------------------------------------------------------
// lru_write_back_tag_cache
// Fully associative write-back tag cache with true LRU replacement, built as
// a row of entry cells.
// ---------------------------------------------------------------------------
// Takes one lookup beat per clock cycle and returns its result from an
// output register; input stall is raised only while a result
// is held and the output side stalls. A read hit reports the entry and makes
// it most recent; a read miss changes nothing and reports way 0. A write
// fills the matching entry, else the lowest free entry, else evicts the
// least recent one (flagging a writeback with the victim's cluster when it
// was dirty). The clock period is set by the tag compare and the match and
// collect chains that ripple through all WAYS cells before the rank update.
// No clearing pass is needed after reset.
module lru_write_back_tag_cache #(
	parameter int WAYS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command,
	input  logic [lwbtc_pkg::TAG_W-1:0]         cluster,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic [lwbtc_pkg::WAY_OUT_W-1:0]     way,
	output logic                                writeback,
	output logic [lwbtc_pkg::TAG_W-1:0]         victim_cluster
);
	import lwbtc_pkg::*;

	localparam int RW = $clog2(WAYS);

	logic          accept;
	ctrl_t         ctrl;
	lookup_t       look [WAYS+1];
	collect_t      coll [WAYS+1];
	logic [RW-1:0] cway [WAYS+1];
	logic [RW-1:0] crank[WAYS+1];
	stat_t         stat [WAYS];
	logic [WAYS-1:0] sel_vec;
	logic [WAYS-1:0] lru_vec;
	logic [WAYS-1:0] valid_vec;

	logic [RW+WAY_OUT_W-1:0] way_ext;
	logic                    evict_wb;

	logic                 out_valid_q;
	logic                 hit_q;
	logic [WAY_OUT_W-1:0] way_q;
	logic                 writeback_q;
	tag_t                 victim_q;

	// Handshake: hold input while a result waits on a stalled output
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// Broadcast control once the lookup chain has settled
	assign ctrl.write     = (cmd_t'(command) == CMD_WRITE);
	assign ctrl.any_match = look[WAYS].match_seen;
	assign ctrl.any_free  = look[WAYS].free_seen;
	assign ctrl.upd       = ctrl.write || look[WAYS].match_seen;

	assign look[0]  = '0;
	assign coll[0]  = '0;
	assign cway[0]  = '0;
	assign crank[0] = '0;

	// Row of entry cells
	for (genvar i = 0; i < WAYS; i++) begin : g_cell
		lwbtc_cell #(
			.WAYS  (WAYS),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.go       (accept),
			.cluster  (cluster),
			.ctrl     (ctrl),
			.upd_rank (crank[WAYS]),
			.look_in  (look[i]),
			.look_out (look[i+1]),
			.coll_in  (coll[i]),
			.coll_out (coll[i+1]),
			.way_in   (cway[i]),
			.way_out  (cway[i+1]),
			.rank_in  (crank[i]),
			.rank_out (crank[i+1]),
			.stat     (stat[i])
		);
		assign sel_vec[i]   = stat[i].sel;
		assign lru_vec[i]   = stat[i].lru;
		assign valid_vec[i] = stat[i].valid;
	end

	// Form the result of the beat
	assign way_ext  = {{WAY_OUT_W{1'b0}}, cway[WAYS]};
	assign evict_wb = ctrl.write && !ctrl.any_match && !ctrl.any_free && coll[WAYS].dirty;

	// Output register: advance on accept, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q       <= ctrl.any_match;
			way_q       <= way_ext[WAY_OUT_W-1:0];
			writeback_q <= evict_wb;
			victim_q    <= evict_wb ? coll[WAYS].tag : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign way            = way_q;
	assign writeback      = writeback_q;
	assign victim_cluster = victim_q;

`ifndef SYNTHESIS
	// At most one entry is selected for any beat
	a_one_sel: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel_vec))
		else $error("more than one entry selected");

	// Exactly one entry holds the least recent rank
	a_one_lru: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(lru_vec))
		else $error("recency ranks are not a permutation");

	// Valid entries always form a prefix starting at entry 0
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + WAYS'(1)) & valid_vec) == '0)
		else $error("valid entries are not a low prefix");

	// After any write, entry 0 is valid
	a_write_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd_t'(command) == CMD_WRITE) |=> valid_vec[0])
		else $error("write did not leave entry 0 valid");

	// A writeback only comes from an eviction, never from a hit
	a_wb_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && writeback_q |-> !hit_q)
		else $error("writeback reported on a hit");
`endif

endmodule

// File: hw/rtl/lwbtc_cell.sv
// ---------------------------------------------------------------------------
// lwbtc_cell
// One cache entry: valid and dirty marks, tag and recency rank. Compares the
// incoming cluster, passes lookup and collect results on to its neighbour
// and updates its own entry when the beat is taken.
// ---------------------------------------------------------------------------
module lwbtc_cell #(
	parameter int WAYS  = 8,
	parameter int INDEX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  lwbtc_pkg::tag_t            cluster,
	input  lwbtc_pkg::ctrl_t           ctrl,
	input  logic [$clog2(WAYS)-1:0]    upd_rank,
	input  lwbtc_pkg::lookup_t         look_in,
	output lwbtc_pkg::lookup_t         look_out,
	input  lwbtc_pkg::collect_t        coll_in,
	output lwbtc_pkg::collect_t        coll_out,
	input  logic [$clog2(WAYS)-1:0]    way_in,
	output logic [$clog2(WAYS)-1:0]    way_out,
	input  logic [$clog2(WAYS)-1:0]    rank_in,
	output logic [$clog2(WAYS)-1:0]    rank_out,
	output lwbtc_pkg::stat_t           stat
);
	import lwbtc_pkg::*;

	localparam int RW = $clog2(WAYS);

	logic          valid_q;
	logic          dirty_q;
	tag_t          tag_q;
	logic [RW-1:0] rank_q;

	logic tag_eq;
	logic match_here;
	logic free_here;
	logic lru_here;
	logic sel_here;

	// Local compare and first-match / first-free detection
	assign tag_eq     = valid_q && (tag_q == cluster);
	assign match_here = tag_eq && !look_in.match_seen;
	assign free_here  = !valid_q && !look_in.free_seen;
	assign lru_here   = (rank_q == RW'(WAYS - 1));

	assign look_out.match_seen = look_in.match_seen | tag_eq;
	assign look_out.free_seen  = look_in.free_seen | !valid_q;

	// Pick this entry: hit first, then free entry, then least recent
	always_comb begin
		if (ctrl.write) begin
			if (ctrl.any_match) begin
				sel_here = match_here;
			end else if (ctrl.any_free) begin
				sel_here = free_here;
			end else begin
				sel_here = lru_here;
			end
		end else begin
			sel_here = match_here;
		end
	end

	// Collect the selected entry's data along the row
	assign coll_out.sel   = coll_in.sel | sel_here;
	assign coll_out.dirty = coll_in.dirty | (sel_here & dirty_q);
	assign coll_out.tag   = coll_in.tag | (sel_here ? tag_q : '0);
	assign way_out        = way_in | (sel_here ? RW'(INDEX) : '0);
	assign rank_out       = rank_in | (sel_here ? rank_q : '0);

	assign stat.sel   = sel_here;
	assign stat.lru   = lru_here;
	assign stat.valid = valid_q;

	// Update marks and recency rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
			rank_q  <= RW'(INDEX);
		end else if (go && ctrl.upd) begin
			if (sel_here) begin
				rank_q <= '0;
				if (ctrl.write) begin
					valid_q <= 1'b1;
					dirty_q <= 1'b1;
				end
			end else if (rank_q < upd_rank) begin
				rank_q <= rank_q + RW'(1);
			end
		end
	end

	// Load the tag on a fill
	always_ff @(posedge clk) begin
		if (go && ctrl.upd && ctrl.write && sel_here) begin
			tag_q <= cluster;
		end
	end

endmodule
